[hw/rtl/lzss_pkg.sv]
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants for the LZSS window decompressor: window
// geometry, token decoding constants and the command passed to the back end.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int WINDOW_SIZE    = 4096;
    localparam int WIN_AW         = $clog2(WINDOW_SIZE);
    localparam int SRC_BIAS       = 18;
    localparam int LEN_BIAS       = 3;
    localparam int LEN_W          = 5;
    localparam int FLAGS_PER_CTRL = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WIN_AW-1:0] t_win_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    typedef enum logic {
        PH_TOKEN,
        PH_REF2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_REF,
        CMD_TRUNC
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_REF_RD,
        BK_REF_WR
    } t_back_state;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        t_win_addr  src;
        t_len       len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clr_busy;
    } t_back_status;

endpackage

[hw/rtl/lzss_front.sv]
// ----------------------------------------------------------------------------
// lzss_front
// Stream parser: tracks control flags, reference byte pairs and the count of
// compressed bytes left, and sends literals and references to the back end.
// ----------------------------------------------------------------------------
module lzss_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_in_byte,
    input  lzss_pkg::t_q_status    i_q_status,
    input  lzss_pkg::t_back_status i_back_status,
    output logic                   o_push,
    output lzss_pkg::t_cmd         o_cmd
);

    logic [7:0]       r_flag_bits, n_flag_bits;
    logic [3:0]       r_flags_left, n_flags_left;
    lzss_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_ref_first, n_ref_first;
    logic [31:0]      r_remaining, n_remaining;
    logic             accept;

    assign o_in_ready = !i_q_status.full && !i_back_status.clr_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_phase      = r_phase;
        n_ref_first  = r_ref_first;
        n_remaining  = r_remaining;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = lzss_pkg::CMD_LIT;
        if (i_cfg_we) begin
            n_flag_bits  = '0;
            n_flags_left = '0;
            n_phase      = lzss_pkg::PH_TOKEN;
            n_ref_first  = '0;
            n_remaining  = i_cfg_data;
        end else if (accept && (r_remaining != '0)) begin
            case (r_phase)
                lzss_pkg::PH_REF2: begin
                    n_remaining = r_remaining - 32'd1;
                    o_push      = 1'b1;
                    o_cmd.kind  = lzss_pkg::CMD_REF;
                    o_cmd.src   = lzss_pkg::t_win_addr'({i_in_byte[7:4], r_ref_first})
                                + lzss_pkg::t_win_addr'(lzss_pkg::SRC_BIAS);
                    o_cmd.len   = lzss_pkg::t_len'({1'b0, i_in_byte[3:0]})
                                + lzss_pkg::t_len'(lzss_pkg::LEN_BIAS);
                    n_phase     = lzss_pkg::PH_TOKEN;
                    n_flag_bits = {1'b0, r_flag_bits[7:1]};
                    if (r_flags_left != '0) begin
                        n_flags_left = r_flags_left - 4'd1;
                    end
                end
                lzss_pkg::PH_TOKEN: begin
                    if (r_flags_left == '0) begin
                        // control byte: load eight new flags
                        n_remaining  = r_remaining - 32'd1;
                        n_flag_bits  = i_in_byte;
                        n_flags_left = 4'(lzss_pkg::FLAGS_PER_CTRL);
                    end else if (r_flag_bits[0]) begin
                        n_remaining  = r_remaining - 32'd1;
                        o_push       = 1'b1;
                        o_cmd.kind   = lzss_pkg::CMD_LIT;
                        o_cmd.data   = i_in_byte;
                        n_flag_bits  = {1'b0, r_flag_bits[7:1]};
                        n_flags_left = r_flags_left - 4'd1;
                    end else if (r_remaining < 32'd2) begin
                        // reference cut off by end of stream: report and stop
                        n_remaining = '0;
                        o_push      = 1'b1;
                        o_cmd.kind  = lzss_pkg::CMD_TRUNC;
                    end else begin
                        n_remaining = r_remaining - 32'd1;
                        n_ref_first = i_in_byte;
                        n_phase     = lzss_pkg::PH_REF2;
                    end
                end
                default: begin
                    n_phase = lzss_pkg::PH_TOKEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_phase      <= lzss_pkg::PH_TOKEN;
            r_ref_first  <= '0;
            r_remaining  <= '0;
        end else begin
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_phase      <= n_phase;
            r_ref_first  <= n_ref_first;
            r_remaining  <= n_remaining;
        end
    end

endmodule

[hw/rtl/lzss_cmd_queue.sv]
// ----------------------------------------------------------------------------
// lzss_cmd_queue
// Short command queue between parser and window engine so each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module lzss_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzss_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output lzss_pkg::t_cmd      o_cmd,
    output lzss_pkg::t_q_status o_status
);

    lzss_pkg::t_cmd  r_slot [lzss_pkg::QUEUE_DEPTH];
    lzss_pkg::t_qptr r_wptr, n_wptr;
    lzss_pkg::t_qptr r_rptr, n_rptr;
    lzss_pkg::t_qcnt r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == lzss_pkg::t_qcnt'(lzss_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == lzss_pkg::t_qptr'(lzss_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_wptr + lzss_pkg::t_qptr'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == lzss_pkg::t_qptr'(lzss_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_rptr + lzss_pkg::t_qptr'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + lzss_pkg::t_qcnt'(1);
            2'b01:   n_count = r_count - lzss_pkg::t_qcnt'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/lzss_back.sv]
// ----------------------------------------------------------------------------
// lzss_back
// Window engine: owns the 4096-byte history memory, clears it after reset,
// executes literal, reference and truncation commands and drives the output
// register.
// ----------------------------------------------------------------------------
module lzss_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lzss_pkg::t_cmd         i_cmd,
    input  lzss_pkg::t_q_status    i_q_status,
    output logic                   o_pop,
    output lzss_pkg::t_back_status o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_status
);

    logic [7:0]            r_win [lzss_pkg::WINDOW_SIZE];
    lzss_pkg::t_back_state r_state, n_state;
    lzss_pkg::t_win_addr   r_clr_addr;
    lzss_pkg::t_win_addr   r_wr_pos;
    lzss_pkg::t_win_addr   r_src;
    lzss_pkg::t_len        r_cnt;
    logic [7:0]            r_rd_data;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    logic                  r_out_status;

    logic                  slot_free;
    logic                  mem_we;
    lzss_pkg::t_win_addr   mem_waddr;
    logic [7:0]            mem_wdata;
    logic                  rd_en;
    logic                  out_load;
    logic [7:0]            out_byte;
    logic                  out_last;
    logic                  out_status;
    logic                  ref_load;
    logic                  ref_adv;
    logic                  wr_adv;
    logic                  clr_adv;

    assign slot_free         = !r_out_valid || i_out_ready;
    assign o_status.clr_busy = (r_state == lzss_pkg::BK_CLEAR);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzss_pkg::BK_CLEAR: begin
                if (r_clr_addr == lzss_pkg::t_win_addr'(lzss_pkg::WINDOW_SIZE - 1)) begin
                    n_state = lzss_pkg::BK_IDLE;
                end
            end
            lzss_pkg::BK_IDLE: begin
                if (!i_q_status.empty && (i_cmd.kind == lzss_pkg::CMD_REF)) begin
                    n_state = lzss_pkg::BK_REF_RD;
                end
            end
            lzss_pkg::BK_REF_RD: begin
                n_state = lzss_pkg::BK_REF_WR;
            end
            lzss_pkg::BK_REF_WR: begin
                if (slot_free) begin
                    n_state = (r_cnt == lzss_pkg::t_len'(1)) ? lzss_pkg::BK_IDLE
                                                             : lzss_pkg::BK_REF_RD;
                end
            end
            default: begin
                n_state = lzss_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_wr_pos;
        mem_wdata  = r_rd_data;
        rd_en      = 1'b0;
        o_pop      = 1'b0;
        out_load   = 1'b0;
        out_byte   = r_rd_data;
        out_last   = 1'b0;
        out_status = 1'b0;
        ref_load   = 1'b0;
        ref_adv    = 1'b0;
        wr_adv     = 1'b0;
        clr_adv    = 1'b0;
        case (r_state)
            lzss_pkg::BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                clr_adv   = 1'b1;
            end
            lzss_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_cmd.kind)
                        lzss_pkg::CMD_LIT: begin
                            if (slot_free) begin
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.data;
                                out_load  = 1'b1;
                                out_byte  = i_cmd.data;
                                out_last  = 1'b1;
                                wr_adv    = 1'b1;
                                o_pop     = 1'b1;
                            end
                        end
                        lzss_pkg::CMD_REF: begin
                            ref_load = 1'b1;
                            o_pop    = 1'b1;
                        end
                        lzss_pkg::CMD_TRUNC: begin
                            if (slot_free) begin
                                out_load   = 1'b1;
                                out_byte   = '0;
                                out_last   = 1'b1;
                                out_status = 1'b1;
                                o_pop      = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            lzss_pkg::BK_REF_RD: begin
                rd_en = 1'b1;
            end
            lzss_pkg::BK_REF_WR: begin
                if (slot_free) begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    out_last = (r_cnt == lzss_pkg::t_len'(1));
                    wr_adv   = 1'b1;
                    ref_adv  = 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzss_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_wr_pos    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_adv) begin
                r_clr_addr <= r_clr_addr + lzss_pkg::t_win_addr'(1);
            end
            if (wr_adv) begin
                r_wr_pos <= r_wr_pos + lzss_pkg::t_win_addr'(1);
            end
            if (ref_load) begin
                r_cnt <= i_cmd.len;
            end else if (ref_adv) begin
                r_cnt <= r_cnt - lzss_pkg::t_len'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ref_load) begin
            r_src <= i_cmd.src;
        end else if (ref_adv) begin
            r_src <= r_src + lzss_pkg::t_win_addr'(1);
        end
        if (out_load) begin
            r_out_byte   <= out_byte;
            r_out_last   <= out_last;
            r_out_status <= out_status;
        end
    end

    // history memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_win[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_win[r_src];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzss_pkg::BK_CLEAR) |-> !o_pop)
        else $error("command taken during window clear");

    a_ref_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lzss_pkg::BK_REF_RD) || (r_state == lzss_pkg::BK_REF_WR))
        |-> (r_cnt != '0))
        else $error("reference copy running with zero count");

    a_store_is_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state != lzss_pkg::BK_CLEAR)) |-> out_load)
        else $error("window write without matching output byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("pending output byte lost");

endmodule

[hw/rtl/lzss_window_decompressor.sv]
// ----------------------------------------------------------------------------
// lzss_window_decompressor
// LZSS decoder with a 4096-byte history window, one compressed byte per
// transfer in, one decompressed byte per transfer out.
// ----------------------------------------------------------------------------
// After reset the block clears the window, one entry a cycle, and holds
// o_in_ready low meanwhile; configuration writes are taken at any time.
// Write the compressed length through i_cfg_we/i_cfg_data before each
// stream. Control bytes and first reference bytes produce no output. A
// literal is written to the window and the output register straight from
// the idle state. A reference is dispatched and then copied (3 to 18
// bytes), each byte read from the window and written back before the
// next read is issued, so an overlapping copy sees the bytes it has just
// written. A two-entry command queue lets the parser keep taking bytes while
// a reference is still being copied.
// ----------------------------------------------------------------------------
module lzss_window_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_out_status
);

    lzss_pkg::t_q_status    q_status;
    lzss_pkg::t_back_status back_status;
    lzss_pkg::t_cmd         push_cmd;
    lzss_pkg::t_cmd         head_cmd;
    logic                   push;
    logic                   pop;

    lzss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_q_status    (q_status),
        .i_back_status (back_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lzss_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    lzss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_status     (back_status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZSS window decompressor. The bench drives
// compressed bytes under valid/ready with random gaps and output stalls,
// decodes each accepted byte in a local model of the window, and compares
// every output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 130;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
    } t_out_beat;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_status;

    // decoder model state
    logic [7:0]          win_mem [lzss_pkg::WINDOW_SIZE];
    lzss_pkg::t_win_addr wr_ptr;
    logic [7:0]          flag_reg;
    logic [3:0]          flag_cnt;
    lzss_pkg::t_phase    parse_phase;
    logic [7:0]          ref_lo;
    logic [31:0]         left_count;

    t_out_beat   pending_bytes [$];
    t_out_beat   want;
    int          errors      = 0;
    int          taken       = 0;
    int          rx_wait     = 0;
    int          cycle_count = 0;
    bit          no_idle     = 1'b0;

    // stream generator state
    logic [7:0]  gen_flags;
    int          gen_left;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lzss_window_decompressor dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (out_byte),
        .o_out_last   (out_last),
        .o_out_status (out_status)
    );

    task automatic store_window(input logic [7:0] d);
        win_mem[wr_ptr] = d;
        wr_ptr = wr_ptr + lzss_pkg::t_win_addr'(1);
    endtask

    task automatic advance_flag();
        flag_reg = flag_reg >> 1;
        if (flag_cnt != 4'd0) flag_cnt = flag_cnt - 4'd1;
    endtask

    // Decode one accepted stream byte and queue the bytes it produces.
    task automatic decode_byte(input logic [7:0] b);
        lzss_pkg::t_win_addr src;
        int                  len;
        int                  i;
        logic [7:0]          d;
        if (left_count == 0) return;
        taken++;
        if (parse_phase == lzss_pkg::PH_REF2) begin
            src = lzss_pkg::t_win_addr'(lzss_pkg::SRC_BIAS) + {b[7:4], ref_lo};
            len = int'(b[3:0]) + lzss_pkg::LEN_BIAS;
            left_count = left_count - 1;
            // copy one byte at a time so overlapping copies see fresh data
            for (i = 0; i < len; i++) begin
                d = win_mem[src + lzss_pkg::t_win_addr'(i)];
                store_window(d);
                pending_bytes.push_back('{data: d, last: (i == len - 1), status: 1'b0});
            end
            parse_phase = lzss_pkg::PH_TOKEN;
            advance_flag();
        end else if (flag_cnt == 4'd0) begin
            left_count = left_count - 1;
            flag_reg   = b;
            flag_cnt   = 4'(lzss_pkg::FLAGS_PER_CTRL);
        end else if (flag_reg[0]) begin
            left_count = left_count - 1;
            store_window(b);
            pending_bytes.push_back('{data: b, last: 1'b1, status: 1'b0});
            advance_flag();
        end else if (left_count < 2) begin
            // reference cut off by the end of the stream
            left_count = 0;
            pending_bytes.push_back('{data: 8'h00, last: 1'b1, status: 1'b1});
        end else begin
            left_count  = left_count - 1;
            ref_lo      = b;
            parse_phase = lzss_pkg::PH_REF2;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        decode_byte(b);
    endtask

    // Send a reference whose source is the absolute window position pos.
    task automatic send_ref(input lzss_pkg::t_win_addr pos, input logic [3:0] nib);
        lzss_pkg::t_win_addr raw;
        raw = pos - lzss_pkg::t_win_addr'(lzss_pkg::SRC_BIAS);
        send_byte(raw[7:0]);
        send_byte({raw[11:8], nib});
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input logic [31:0] len);
        in_valid <= 1'b0;
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we      <= 1'b0;
        left_count  = len;
        flag_reg    = '0;
        flag_cnt    = '0;
        parse_phase = lzss_pkg::PH_TOKEN;
        ref_lo      = '0;
    endtask

    // Mostly well-formed groups: control byte, then literals and references.
    task automatic send_stream(input int count);
        int sent;
        sent     = 0;
        gen_left = 0;
        while (sent < count) begin
            if ($urandom_range(0, 19) == 0) begin
                send_byte(8'($urandom));
                sent++;
            end else if (gen_left == 0) begin
                gen_flags = 8'($urandom);
                gen_left  = lzss_pkg::FLAGS_PER_CTRL;
                send_byte(gen_flags);
                sent++;
            end else begin
                if (gen_flags[0]) begin
                    send_byte(8'($urandom));
                    sent++;
                end else begin
                    if ($urandom_range(0, 1) == 1)
                        send_ref(wr_ptr - lzss_pkg::t_win_addr'($urandom_range(1, 24)),
                                 4'($urandom));
                    else begin
                        send_byte(8'($urandom));
                        send_byte(8'($urandom));
                    end
                    sent += 2;
                end
                gen_flags = gen_flags >> 1;
                gen_left--;
            end
        end
    endtask

    task automatic test_literals();
        set_length(32'd9);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h55);
        send_byte(8'hAA);
        // stream used up: dropped
        send_byte(8'h3C);
    endtask

    task automatic test_references();
        set_length(32'd9);
        send_byte(8'hF0);
        send_ref(wr_ptr - lzss_pkg::t_win_addr'(1), 4'hF);
        send_ref(wr_ptr - lzss_pkg::t_win_addr'(3), 4'h0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    task automatic test_truncation();
        set_length(32'd2);
        send_byte(8'h00);
        send_byte(8'h3C);
        send_byte(8'h11);
    endtask

    task automatic test_stream_end();
        set_length(32'd0);
        send_byte(8'hC3);
        send_byte(8'h00);
        // control byte as the final stream byte
        set_length(32'd1);
        send_byte(8'h00);
    endtask

    task automatic test_random();
        int          start;
        logic [31:0] len;
        start = taken;
        while (taken - start < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: len = 32'hFFFF_FFFF;
                1: len = $urandom_range(1, 3);
                default: len = $urandom_range(4, 48);
            endcase
            set_length(len);
            send_stream((len == 32'hFFFF_FFFF) ? 48 : int'(len) + $urandom_range(0, 2));
        end
        no_idle = 1'b0;
    endtask

    // output side: random stall after each transfer, compare against model
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected output: out_byte %0h last %0b status %0b",
                       out_byte, out_last, out_status);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data) begin
                    $error("out_byte expected %0h actual %0h", want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, out_last);
                    errors++;
                end
                if (out_status !== want.status) begin
                    $error("status expected %0b actual %0b", want.status, out_status);
                    errors++;
                end
            end
            rx_wait = no_idle ? 0 : $urandom_range(0, 15);
            if (rx_wait != 0) out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (rx_wait > 0) rx_wait--;
            if (rx_wait == 0) out_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lzss_window_decompressor: mismatch");
        $finish;
    end

    initial begin
        foreach (win_mem[i]) win_mem[i] = '0;
        wr_ptr      = '0;
        flag_reg    = '0;
        flag_cnt    = '0;
        parse_phase = lzss_pkg::PH_TOKEN;
        ref_lo      = '0;
        left_count  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_literals();
        test_references();
        test_truncation();
        test_stream_end();
        test_random();
        in_valid <= 1'b0;
        wait_idle();
        if (errors == 0)
            $display("lzss_window_decompressor: match");
        else
            $display("lzss_window_decompressor: mismatch");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_front.sv
hw/rtl/lzss_cmd_queue.sv
hw/rtl/lzss_back.sv
hw/rtl/lzss_window_decompressor.sv
tb/tb.sv
